>>> rtl/usbcts_pkg.sv
// Package for the USB endpoint 0 control transfer sequencer.
// Holds the event and result word types, command, action and phase codes, and the phase enum.
// No dependencies.
package usbcts_pkg;

    localparam int CMD_W    = 3;
    localparam int LEN_W    = 16;
    localparam int RX_W     = 7;
    localparam int ACTION_W = 3;
    localparam int OFFSET_W = 10;
    localparam int PKT_W    = 7;
    localparam int PHASE_W  = 3;

    localparam logic [CMD_W-1:0] CMD_START_IN  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START_OUT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_IN_DONE   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_OUT_RX    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SETUP     = 3'd4;

    localparam logic [ACTION_W-1:0] ACT_NONE        = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_SEND        = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_SEND_ZERO   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_ACCEPT      = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_STALL       = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_COMPLETE    = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_READ_ZERO   = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_ACCEPT_ZERO = 3'd7;

    localparam logic [PHASE_W-1:0] PH_IDLE          = 3'd0;
    localparam logic [PHASE_W-1:0] PH_DATA_IN       = 3'd1;
    localparam logic [PHASE_W-1:0] PH_LAST_DATA_IN  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_STATUS_IN     = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DATA_OUT      = 3'd4;
    localparam logic [PHASE_W-1:0] PH_LAST_DATA_OUT = 3'd5;
    localparam logic [PHASE_W-1:0] PH_STATUS_OUT    = 3'd6;

    typedef enum logic [6:0] {
        S_IDLE          = 7'b0000001,
        S_DATA_IN       = 7'b0000010,
        S_LAST_DATA_IN  = 7'b0000100,
        S_STATUS_IN     = 7'b0001000,
        S_DATA_OUT      = 7'b0010000,
        S_LAST_DATA_OUT = 7'b0100000,
        S_STATUS_OUT    = 7'b1000000
    } t_state;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [LEN_W-1:0] data_length;
        logic [LEN_W-1:0] request_length;
        logic [RX_W-1:0]  received_bytes;
    } t_in_word;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [OFFSET_W-1:0] buffer_offset;
        logic [PKT_W-1:0]    packet_length;
        logic [PHASE_W-1:0]  phase;
        logic                out_nak;
    } t_out_word;

    function automatic logic [PHASE_W-1:0] phase_code(input t_state s);
        logic [PHASE_W-1:0] c;
        case (s)
            S_IDLE:          c = PH_IDLE;
            S_DATA_IN:       c = PH_DATA_IN;
            S_LAST_DATA_IN:  c = PH_LAST_DATA_IN;
            S_STATUS_IN:     c = PH_STATUS_IN;
            S_DATA_OUT:      c = PH_DATA_OUT;
            S_LAST_DATA_OUT: c = PH_LAST_DATA_OUT;
            S_STATUS_OUT:    c = PH_STATUS_OUT;
            default:         c = PH_IDLE;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/usb_control_transfer_sequencer.sv
// Top level of the USB endpoint 0 control transfer sequencer.
// Depends on usbcts_pkg for the word types and the command, action and phase codes.
//
// The sequencer takes one event word per clock and gives one result word for each. The event
// is held in an input register, then one pass of logic updates the phase, byte count, offset
// and zero-length flag and loads the result register, from which the result word is presented.
// While a result waits on a stalled output, the input register can still take one word and then
// stalls the input. The block sustains one event per cycle whenever the result side does not
// stall. IN data is cut into packets of MAX_PACKET_BYTES with a trailing zero-length packet
// where needed, and lengths are clamped to BUFFER_BYTES.
module usb_control_transfer_sequencer
    import usbcts_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = 64,
    parameter int BUFFER_BYTES     = 512
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_word  i_in_word,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_word o_out_word,
    input  logic      i_out_stall
);

    localparam int CNT_W   = $clog2(BUFFER_BYTES + 1);
    localparam int DIV_K   = CNT_W + 8;
    localparam int RECIP_W = DIV_K - 2;
    localparam logic [CNT_W-1:0]   MPB_C   = CNT_W'(MAX_PACKET_BYTES);
    localparam logic [PKT_W-1:0]   MPB_P   = PKT_W'(MAX_PACKET_BYTES);
    localparam logic [CNT_W-1:0]   BUF_C   = CNT_W'(BUFFER_BYTES);
    localparam logic [LEN_W-1:0]   BUF_L   = LEN_W'(BUFFER_BYTES);
    localparam logic [RECIP_W-1:0] RECIP   =
        RECIP_W'((2 ** DIV_K + MAX_PACKET_BYTES - 1) / MAX_PACKET_BYTES);
    localparam logic [RX_W-1:0]    SETUP_B = RX_W'(8);

    logic      r_in_valid;
    t_in_word  r_in;
    logic      r_out_valid;
    t_out_word r_out;
    logic      advance;
    logic      in_accept;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_offset, n_offset;
    logic             r_zpp, n_zpp;
    logic [LEN_W-1:0] r_req, n_req;
    logic             r_nak, n_nak;

    logic [ACTION_W-1:0] res_action;
    logic [CNT_W-1:0]    res_off;
    logic [PKT_W-1:0]    res_len;

    logic [CNT_W-1:0]         dlen_c;
    logic [CNT_W+RECIP_W-1:0] div_prod;
    logic                     dlen_mult;
    logic                     zpp0;
    logic [CNT_W-1:0]         sn_count, sn_offset;
    logic                     sn_zpp;
    logic                     sn_big;
    logic [CNT_W-1:0]         out_len_reg, out_len_new;
    logic [CNT_W-1:0]         out_left;
    logic [PKT_W-1:0]         want;
    logic                     rx_short;
    logic [CNT_W-1:0]         count_plus;
    logic [CNT_W-1:0]         left_after;

    assign advance     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !advance;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // Divisibility test by multiplying with a rounded-up reciprocal: the low bits of the
    // product fall below the reciprocal exactly when the length is a multiple of a packet.
    assign dlen_c    = (r_in.data_length > BUF_L) ? BUF_C : r_in.data_length[CNT_W-1:0];
    assign div_prod  = dlen_c * RECIP;
    assign dlen_mult = div_prod[DIV_K-1:0] < DIV_K'(RECIP);
    assign zpp0      = (dlen_c != '0) && (LEN_W'(dlen_c) < r_in.request_length) && dlen_mult;

    assign sn_count  = (r_in.command == CMD_START_IN) ? dlen_c : r_count;
    assign sn_offset = (r_in.command == CMD_START_IN) ? '0 : r_offset;
    assign sn_zpp    = (r_in.command == CMD_START_IN) ? zpp0 : r_zpp;
    assign sn_big    = sn_count > MPB_C;

    assign out_len_reg = (r_req > BUF_L) ? BUF_C : r_req[CNT_W-1:0];
    assign out_len_new = (r_in.request_length > BUF_L) ? BUF_C
                                                       : r_in.request_length[CNT_W-1:0];
    assign out_left    = out_len_reg - r_count;
    assign want        = (out_left > MPB_C) ? MPB_P : out_left[PKT_W-1:0];
    assign rx_short    = r_in.received_bytes < want;
    assign count_plus  = r_count + CNT_W'(want);
    assign left_after  = out_len_reg - count_plus;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_offset   = r_offset;
        n_zpp      = r_zpp;
        n_req      = r_req;
        n_nak      = r_nak;
        res_action = ACT_NONE;
        res_off    = '0;
        res_len    = '0;
        case (r_in.command)
            CMD_START_IN, CMD_IN_DONE: begin
                if (r_in.command == CMD_START_IN) begin
                    n_req = r_in.request_length;
                end
                if (r_in.command == CMD_START_IN || r_state == S_DATA_IN) begin
                    res_action = ACT_SEND;
                    res_off    = sn_offset;
                    if (sn_big) begin
                        res_len  = MPB_P;
                        n_state  = S_DATA_IN;
                        n_offset = sn_offset + MPB_C;
                        n_count  = sn_count - MPB_C;
                        n_zpp    = sn_zpp;
                    end else begin
                        res_len  = sn_count[PKT_W-1:0];
                        n_state  = sn_zpp ? S_DATA_IN : S_LAST_DATA_IN;
                        n_offset = '0;
                        n_count  = '0;
                        n_zpp    = 1'b0;
                    end
                end else if (r_state == S_LAST_DATA_IN) begin
                    n_state = S_STATUS_OUT;
                    n_nak   = 1'b0;
                end else if (r_state == S_STATUS_IN) begin
                    n_state    = S_IDLE;
                    res_action = ACT_COMPLETE;
                end else begin
                    n_state    = S_IDLE;
                    res_action = ACT_STALL;
                end
            end
            CMD_START_OUT: begin
                n_req   = r_in.request_length;
                n_count = '0;
                n_state = (out_len_new > MPB_C) ? S_DATA_OUT : S_LAST_DATA_OUT;
                n_nak   = 1'b0;
            end
            CMD_OUT_RX: begin
                if (r_state == S_DATA_OUT || r_state == S_LAST_DATA_OUT) begin
                    if (rx_short) begin
                        n_state    = S_IDLE;
                        res_action = ACT_STALL;
                    end else begin
                        res_off = r_count;
                        res_len = want;
                        n_count = count_plus;
                        if (r_state == S_DATA_OUT) begin
                            res_action = ACT_ACCEPT;
                            if (left_after <= MPB_C) begin
                                n_state = S_LAST_DATA_OUT;
                            end
                        end else begin
                            res_action = ACT_ACCEPT_ZERO;
                            n_state    = S_STATUS_IN;
                        end
                    end
                end else if (r_state == S_STATUS_OUT) begin
                    res_action = ACT_READ_ZERO;
                    n_state    = S_IDLE;
                end else begin
                    n_state    = S_IDLE;
                    res_action = ACT_STALL;
                end
            end
            CMD_SETUP: begin
                n_nak    = 1'b1;
                n_req    = r_in.request_length;
                n_state  = S_IDLE;
                n_count  = '0;
                n_offset = '0;
                n_zpp    = 1'b0;
                if (r_in.received_bytes != SETUP_B) begin
                    res_action = ACT_STALL;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_offset    <= '0;
            r_zpp       <= 1'b0;
            r_req       <= '0;
            r_nak       <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
                r_count     <= n_count;
                r_offset    <= n_offset;
                r_zpp       <= n_zpp;
                r_req       <= n_req;
                r_nak       <= n_nak;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_word;
        end
        if (advance) begin
            r_out.action        <= res_action;
            r_out.buffer_offset <= OFFSET_W'(res_off);
            r_out.packet_length <= res_len;
            r_out.phase         <= phase_code(n_state);
            r_out.out_nak       <= n_nak;
        end
    end

    a_setup_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in.command == CMD_SETUP
        |=> o_out_valid && o_out_word.out_nak && o_out_word.phase == PH_IDLE)
        else $error("setup event did not return to idle with OUT NAK set");

    a_stall_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.action == ACT_STALL |-> o_out_word.phase == PH_IDLE)
        else $error("stall result left the sequencer outside idle");

    a_pkt_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.action == ACT_SEND || o_out_word.action == ACT_ACCEPT)
        |-> o_out_word.packet_length <= MPB_P)
        else $error("packet longer than the maximum packet size");

    a_hold_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in))
        else $error("pending event word lost or overwritten");

    a_out_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DATA_OUT || r_state == S_LAST_DATA_OUT) |-> r_count <= out_len_reg)
        else $error("OUT byte count beyond the transfer length");

endmodule

>>> test/tb_usb_control_transfer_sequencer.sv
// Testbench for the USB endpoint 0 control transfer sequencer: directed stages, then random transfers.
// Every result word is checked against a behavioural copy of the sequencer held here.
// Depends on usbcts_pkg and usb_control_transfer_sequencer.
module tb_usb_control_transfer_sequencer
    import usbcts_pkg::*;
();

    localparam int PACKET_BYTES = 64;
    localparam int BUFFER_BYTES = 512;
    localparam int SETUP_BYTES  = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [CMD_W-1:0] CMD_FIRST_SPARE = 3'd5;
    localparam logic [CMD_W-1:0] CMD_LAST_SPARE  = 3'd7;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    t_in_word  i_in_word = '0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word o_out_word;
    logic      i_out_stall = 1'b0;

    usb_control_transfer_sequencer #(
        .MAX_PACKET_BYTES(PACKET_BYTES),
        .BUFFER_BYTES(BUFFER_BYTES)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .i_in_word(i_in_word),
        .o_in_stall(o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out_word(o_out_word),
        .i_out_stall(i_out_stall)
    );

    always #2 i_clk = ~i_clk;

    // Sequencer state as the design should hold it.
    logic [PHASE_W-1:0]  m_phase = PH_IDLE;
    logic [OFFSET_W-1:0] m_count = '0;
    logic [OFFSET_W-1:0] m_offset = '0;
    logic                m_zlp = 1'b0;
    logic [LEN_W-1:0]    m_req = '0;
    logic                m_nak = 1'b0;
    t_out_word           m_res;

    t_out_word expected_results[$];
    int        mismatches = 0;
    int        sent_items = 0;
    int        cycle_count = 0;
    int        stall_left = 0;
    bit        sender_idles = 1'b1;
    bit        receiver_stalls = 1'b1;

    function automatic int out_len();
        return (int'(m_req) < BUFFER_BYTES) ? int'(m_req) : BUFFER_BYTES;
    endfunction

    function automatic void stall_to_idle();
        m_res.action = ACT_STALL;
        m_phase = PH_IDLE;
    endfunction

    function automatic void send_in_packet();
        m_res.action = ACT_SEND;
        m_res.buffer_offset = m_offset;
        if (int'(m_count) > PACKET_BYTES) begin
            m_res.packet_length = PKT_W'(PACKET_BYTES);
            m_phase = PH_DATA_IN;
            m_offset = m_offset + OFFSET_W'(PACKET_BYTES);
            m_count = m_count - OFFSET_W'(PACKET_BYTES);
        end else begin
            m_res.packet_length = PKT_W'(m_count);
            m_phase = m_zlp ? PH_DATA_IN : PH_LAST_DATA_IN;
            m_offset = '0;
            m_zlp = 1'b0;
            m_count = '0;
        end
    endfunction

    function automatic bit take_out_packet(input int rx, input logic [ACTION_W-1:0] act);
        int want;
        want = out_len() - int'(m_count);
        if (want > PACKET_BYTES) want = PACKET_BYTES;
        if (rx < want) begin
            stall_to_idle();
            return 1'b0;
        end
        m_res.action = act;
        m_res.buffer_offset = m_count;
        m_res.packet_length = PKT_W'(want);
        m_count = m_count + OFFSET_W'(want);
        return 1'b1;
    endfunction

    function automatic t_out_word sequencer_step(input t_in_word w);
        m_res = '0;
        case (w.command)
            CMD_START_IN: begin
                m_req = w.request_length;
                m_count = (int'(w.data_length) > BUFFER_BYTES) ? OFFSET_W'(BUFFER_BYTES)
                                                               : OFFSET_W'(w.data_length);
                m_offset = '0;
                m_zlp = (m_count != 0) && (m_count < m_req)
                        && ((int'(m_count) % PACKET_BYTES) == 0);
                send_in_packet();
            end
            CMD_START_OUT: begin
                m_req = w.request_length;
                m_count = '0;
                m_phase = (out_len() > PACKET_BYTES) ? PH_DATA_OUT : PH_LAST_DATA_OUT;
                m_nak = 1'b0;
            end
            CMD_IN_DONE: begin
                if (m_phase == PH_DATA_IN) begin
                    send_in_packet();
                end else if (m_phase == PH_LAST_DATA_IN) begin
                    m_phase = PH_STATUS_OUT;
                    m_nak = 1'b0;
                end else if (m_phase == PH_STATUS_IN) begin
                    m_phase = PH_IDLE;
                    m_res.action = ACT_COMPLETE;
                end else begin
                    stall_to_idle();
                end
            end
            CMD_OUT_RX: begin
                if (m_phase == PH_DATA_OUT) begin
                    if (take_out_packet(int'(w.received_bytes), ACT_ACCEPT)
                        && (out_len() - int'(m_count) <= PACKET_BYTES))
                        m_phase = PH_LAST_DATA_OUT;
                end else if (m_phase == PH_LAST_DATA_OUT) begin
                    if (take_out_packet(int'(w.received_bytes), ACT_ACCEPT_ZERO))
                        m_phase = PH_STATUS_IN;
                end else if (m_phase == PH_STATUS_OUT) begin
                    m_res.action = ACT_READ_ZERO;
                    m_phase = PH_IDLE;
                end else begin
                    stall_to_idle();
                end
            end
            CMD_SETUP: begin
                m_nak = 1'b1;
                m_req = w.request_length;
                m_phase = PH_IDLE;
                m_count = '0;
                m_offset = '0;
                m_zlp = 1'b0;
                if (int'(w.received_bytes) != SETUP_BYTES) m_res.action = ACT_STALL;
            end
            default: begin
            end
        endcase
        m_res.phase = m_phase;
        m_res.out_nak = m_nak;
        return m_res;
    endfunction

    function automatic t_in_word make_word(input logic [CMD_W-1:0] cmd, input int dlen,
                                           input int rlen, input int rx);
        t_in_word w;
        w.command = cmd;
        w.data_length = LEN_W'(dlen);
        w.request_length = LEN_W'(rlen);
        w.received_bytes = RX_W'(rx);
        return w;
    endfunction

    function automatic int pick_length();
        int n;
        case ($urandom_range(0, 9))
            0: n = 0;
            1: n = $urandom_range(1, 8) * PACKET_BYTES;
            2: n = $urandom_range(0, 65535);
            3: n = 65535;
            4: n = $urandom_range(BUFFER_BYTES - 2, BUFFER_BYTES + 2);
            default: n = $urandom_range(0, 200);
        endcase
        return n;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatches++;
        $display("mismatch: %s", msg);
    endtask

    task automatic send_event(input t_in_word w);
        if (sender_idles && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (o_in_stall);
        expected_results.push_back(sequencer_step(w));
        if (w.command < CMD_FIRST_SPARE) sent_items++;
    endtask

    task automatic send_setup(input int rlen);
        int rx;
        rx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : SETUP_BYTES;
        send_event(make_word(CMD_SETUP, $urandom_range(0, 65535), rlen, rx));
    endtask

    task automatic send_noise();
        send_event(make_word(CMD_W'($urandom_range(0, 7)), $urandom_range(0, 65535),
                             $urandom_range(0, 65535), $urandom_range(0, 127)));
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    task automatic test_setup_words();
        send_event(make_word(CMD_SETUP, 0, 0, SETUP_BYTES));
        send_event(make_word(CMD_SETUP, 65535, 0, 0));
        send_event(make_word(CMD_SETUP, 0, 65535, 127));
    endtask

    task automatic test_in_stage();
        // Zero-length data stage, then a full packet that needs a trailing zero-length packet.
        send_event(make_word(CMD_START_IN, 0, 0, 0));
        send_event(make_word(CMD_IN_DONE, 0, 0, 0));
        send_event(make_word(CMD_OUT_RX, 0, 0, 0));
        send_event(make_word(CMD_START_IN, PACKET_BYTES, 100, 0));
        send_event(make_word(CMD_IN_DONE, 0, 0, 0));
        send_event(make_word(CMD_IN_DONE, 0, 0, 0));
        send_event(make_word(CMD_OUT_RX, 0, 0, 64));
        // A long data stage, with the transfer cut short by a new setup before its status stage.
        send_event(make_word(CMD_START_IN, 130, 65535, 0));
        send_event(make_word(CMD_IN_DONE, 0, 0, 0));
        send_event(make_word(CMD_IN_DONE, 0, 0, 0));
        send_event(make_word(CMD_IN_DONE, 0, 0, 0));
        send_event(make_word(CMD_SETUP, 0, 0, SETUP_BYTES));
    endtask

    task automatic test_out_stage();
        send_event(make_word(CMD_START_OUT, 0, 0, 0));
        send_event(make_word(CMD_OUT_RX, 0, 0, 0));
        send_event(make_word(CMD_IN_DONE, 0, 0, 0));
        // Extra bytes in the last packet are ignored.
        send_event(make_word(CMD_START_OUT, 0, 100, 0));
        send_event(make_word(CMD_OUT_RX, 0, 0, 64));
        send_event(make_word(CMD_OUT_RX, 0, 0, 127));
        send_event(make_word(CMD_IN_DONE, 0, 0, 0));
        // A short packet stalls.
        send_event(make_word(CMD_START_OUT, 0, 65535, 0));
        send_event(make_word(CMD_OUT_RX, 0, 0, 10));
    endtask

    task automatic test_bad_events();
        send_event(make_word(CMD_IN_DONE, 0, 0, 0));
        send_event(make_word(CMD_OUT_RX, 0, 0, 64));
        for (int c = int'(CMD_FIRST_SPARE); c <= int'(CMD_LAST_SPARE); c++)
            send_event(make_word(CMD_W'(c), 65535, 65535, 127));
    endtask

    task automatic random_in_transfer();
        int dlen;
        int rlen;
        int guard;
        dlen = pick_length();
        case ($urandom_range(0, 3))
            0: rlen = dlen;
            1: rlen = pick_length();
            2: rlen = dlen + $urandom_range(1, PACKET_BYTES);
            default: rlen = $urandom_range(0, 65535);
        endcase
        if (rlen > 65535) rlen = 65535;
        send_setup(rlen);
        send_event(make_word(CMD_START_IN, dlen, rlen, $urandom_range(0, 127)));
        guard = 0;
        while ((m_phase == PH_DATA_IN || m_phase == PH_LAST_DATA_IN) && guard < 12) begin
            if ($urandom_range(0, 39) == 0)
                send_noise();
            else
                send_event(make_word(CMD_IN_DONE, $urandom_range(0, 65535),
                                     $urandom_range(0, 65535), $urandom_range(0, 127)));
            guard++;
        end
        if (m_phase == PH_STATUS_OUT)
            send_event(make_word(CMD_OUT_RX, $urandom_range(0, 65535),
                                 $urandom_range(0, 65535), $urandom_range(0, 127)));
    endtask

    task automatic random_out_transfer();
        int rlen;
        int want;
        int rx;
        int guard;
        rlen = pick_length();
        send_setup(rlen);
        send_event(make_word(CMD_START_OUT, $urandom_range(0, 65535), rlen,
                             $urandom_range(0, 127)));
        guard = 0;
        while ((m_phase == PH_DATA_OUT || m_phase == PH_LAST_DATA_OUT) && guard < 12) begin
            want = out_len() - int'(m_count);
            if (want > PACKET_BYTES) want = PACKET_BYTES;
            case ($urandom_range(0, 15))
                0: rx = (want > 0) ? $urandom_range(0, want - 1) : 0;
                1: rx = $urandom_range(want, 127);
                default: rx = want;
            endcase
            if ($urandom_range(0, 39) == 0)
                send_noise();
            else
                send_event(make_word(CMD_OUT_RX, $urandom_range(0, 65535),
                                     $urandom_range(0, 65535), rx));
            guard++;
        end
        if (m_phase == PH_STATUS_IN)
            send_event(make_word(CMD_IN_DONE, $urandom_range(0, 65535),
                                 $urandom_range(0, 65535), $urandom_range(0, 127)));
    endtask

    task automatic test_random_transfers(input int target);
        int goal;
        goal = sent_items + target;
        while (sent_items < goal) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: random_in_transfer();
                4, 5, 6, 7: random_out_transfer();
                default: send_noise();
            endcase
        end
    endtask

    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left--;
            if (stall_left == 0) i_out_stall <= 1'b0;
        end else if (receiver_stalls && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 14);
            i_out_stall <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_out_word exp;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                flag_mismatch($sformatf("unexpected result word %h", o_out_word));
            end else begin
                exp = expected_results.pop_front();
                if (o_out_word.action !== exp.action)
                    flag_mismatch($sformatf("action %0d, want %0d",
                                            o_out_word.action, exp.action));
                if (o_out_word.buffer_offset !== exp.buffer_offset)
                    flag_mismatch($sformatf("buffer_offset %0d, want %0d",
                                            o_out_word.buffer_offset, exp.buffer_offset));
                if (o_out_word.packet_length !== exp.packet_length)
                    flag_mismatch($sformatf("packet_length %0d, want %0d",
                                            o_out_word.packet_length, exp.packet_length));
                if (o_out_word.phase !== exp.phase)
                    flag_mismatch($sformatf("phase %0d, want %0d",
                                            o_out_word.phase, exp.phase));
                if (o_out_word.out_nak !== exp.out_nak)
                    flag_mismatch($sformatf("out_nak %0d, want %0d",
                                            o_out_word.out_nak, exp.out_nak));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("usb_control_transfer_sequencer test failed");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_setup_words();
        test_in_stage();
        test_out_stage();
        test_bad_events();
        wait_for_results();
        test_random_transfers(450);
        sender_idles = 1'b0;
        receiver_stalls = 1'b0;
        test_random_transfers(200);
        sender_idles = 1'b1;
        receiver_stalls = 1'b1;
        wait_for_results();
        test_random_transfers(450);
        sender_idles = 1'b0;
        receiver_stalls = 1'b0;
        test_random_transfers(300);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("usb_control_transfer_sequencer test passed");
        else
            $display("usb_control_transfer_sequencer test failed");
        $finish;
    end

endmodule

>>> files.f
rtl/usbcts_pkg.sv
rtl/usb_control_transfer_sequencer.sv
test/tb_usb_control_transfer_sequencer.sv
